@@ hdl/ssfr_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI frame receiver package
// Shared types and constants for the frame receiver and its byte store.
// ----------------------------------------------------------------------------
package ssfr_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int RESULT_LIMIT  = 16;

    localparam logic [4:0] FRAME_BYTES_RESET = 5'd16;
    localparam logic [7:0] BYTE_MSB_MASK     = 8'h80;

    localparam logic MODE_CLOCK  = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } ssfr_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } ssfr_store_ctl_t;

endpackage

@@ hdl/ssfr_store.sv @@
// ----------------------------------------------------------------------------
// SPI frame byte store
// Synchronous byte memory with a registered read; per-entry valid bits
// make an unwritten entry read as zero and let one clear empty the whole frame.
// ----------------------------------------------------------------------------
module ssfr_store #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ssfr_pkg::ssfr_store_ctl_t ctl,
    input  logic [AW-1:0]           wr_addr,
    input  logic [7:0]              wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic [7:0]              rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // entry never written since the last clear reads as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : 8'h00;

endmodule

@@ hdl/spi_slave_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// SPI slave frame receiver
// Receive-only SPI slave, MSB first, fed with pin events; emits the frame
// bytes from a byte store when select goes high after data arrived.
// ----------------------------------------------------------------------------
// Throughput: one pin event per cycle while no readout runs; each frame byte
//   is read out by a store read (ST_READ), then an output load (ST_LOAD) that waits out any output stall.
// After the select event, a frame's first byte goes through ST_READ, then ST_LOAD.
// Input is held off while a frame is read out of the store.
// Reset (async, active low) resets all control state with select taken as high,
//   clears the store valid bits and sets frame_bytes to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module spi_slave_frame_receiver #(
    parameter int MAX_BYTES = 16
) (
    input  logic       clk,
    input  logic       rst_n,

    // pin event channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       mode,
    input  logic       mosi_bit,
    input  logic       ss_level,

    // frame byte channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic [3:0] byte_index,
    output logic       last_byte,
    output logic       overflow,

    // frame length register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    // Usable capacity: the store never needs more entries than one frame
    // can deliver.
    localparam int CAP   = (MAX_BYTES < ssfr_pkg::RESULT_LIMIT) ?
                           MAX_BYTES : ssfr_pkg::RESULT_LIMIT;
    localparam int AW    = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W = $clog2(ssfr_pkg::BITS_PER_BYTE * CAP + 1);

    ssfr_pkg::ssfr_state_t state_reg, state_next;

    logic [CNT_W-1:0] bit_count_reg, bit_count_next;
    logic [7:0]       acc_reg, acc_next;
    logic             select_high_reg, select_high_next;
    logic             frame_empty_reg, frame_empty_next;
    logic             overflow_seen_reg, overflow_seen_next;
    logic [3:0]       rd_idx_reg, rd_idx_next;
    logic [4:0]       frame_bytes_reg;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       data_byte_reg, data_byte_next;
    logic [3:0]       byte_index_reg, byte_index_next;
    logic             last_byte_reg, last_byte_next;
    logic             overflow_out_reg, overflow_out_next;

    logic             in_fire;
    logic             out_free;
    logic             rd_last;
    logic [4:0]       n_eff;
    logic [7:0]       bit_limit;
    logic [7:0]       wr_byte;
    logic [7:0]       rd_data;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    ssfr_pkg::ssfr_store_ctl_t store_ctl;

    // ------------------------------------------------------------------
    // Configuration: frame length, taken only while idle by contract
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bytes_reg <= ssfr_pkg::FRAME_BYTES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_bytes_reg <= cfg_data;
        end
    end

    // Clamp the programmed length to 1..CAP.
    always_comb
    begin
        if (frame_bytes_reg == 5'd0)
        begin
            n_eff = 5'd1;
        end
        else if (frame_bytes_reg > 5'(CAP))
        begin
            n_eff = 5'(CAP);
        end
        else
        begin
            n_eff = frame_bytes_reg;
        end
    end

    assign bit_limit = {n_eff, 3'b000};

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // Accept pin events whenever no readout runs; the output register
    // decouples a waiting byte from the input side.
    assign in_stall = (state_reg != ssfr_pkg::ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_last  = ((5'(rd_idx_reg) + 5'd1) == n_eff);

    // The byte under assembly is forwarded from acc_reg, so a bit write
    // never waits for a store read. A new byte starts from zero.
    assign wr_byte = ((bit_count_reg[2:0] == 3'd0) ? 8'h00 : acc_reg) |
                     (mosi_bit ? (ssfr_pkg::BYTE_MSB_MASK >> bit_count_reg[2:0]) : 8'h00);
    assign wr_addr = bit_count_reg[3 +: AW];
    assign rd_addr = rd_idx_reg[AW-1:0];

    // ------------------------------------------------------------------
    // Next state and store control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        bit_count_next     = bit_count_reg;
        acc_next           = acc_reg;
        select_high_next   = select_high_reg;
        frame_empty_next   = frame_empty_reg;
        overflow_seen_next = overflow_seen_reg;
        rd_idx_next        = rd_idx_reg;

        // drop the output byte once taken
        out_valid_next     = out_valid_reg && out_stall;
        data_byte_next     = data_byte_reg;
        byte_index_next    = byte_index_reg;
        last_byte_next     = last_byte_reg;
        overflow_out_next  = overflow_out_reg;

        store_ctl          = '0;

        case (state_reg)
            ssfr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode == ssfr_pkg::MODE_CLOCK)
                    begin
                        // ignore clock edges while deselected
                        if (!select_high_reg)
                        begin
                            frame_empty_next = 1'b0;
                            if (8'(bit_count_reg) < bit_limit)
                            begin
                                store_ctl.wr_en = 1'b1;
                                acc_next        = wr_byte;
                                bit_count_next  = bit_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // frame full: drop the bit, flag it
                                overflow_seen_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        select_high_next = ss_level;
                        if (ss_level && !frame_empty_reg)
                        begin
                            rd_idx_next = 4'd0;
                            state_next  = ssfr_pkg::ST_READ;
                        end
                    end
                end
            end

            ssfr_pkg::ST_READ:
            begin
                store_ctl.rd_en = 1'b1;
                state_next      = ssfr_pkg::ST_LOAD;
            end

            ssfr_pkg::ST_LOAD:
            begin
                // hold the read byte until the output register frees up
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    data_byte_next    = rd_data;
                    byte_index_next   = rd_idx_reg;
                    last_byte_next    = rd_last;
                    overflow_out_next = overflow_seen_reg;
                    if (rd_last)
                    begin
                        // frame done: clear store, count and flags
                        store_ctl.clear    = 1'b1;
                        bit_count_next     = '0;
                        frame_empty_next   = 1'b1;
                        overflow_seen_next = 1'b0;
                        state_next         = ssfr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 4'd1;
                        state_next  = ssfr_pkg::ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ssfr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ssfr_pkg::ST_IDLE;
            bit_count_reg     <= '0;
            select_high_reg   <= 1'b1;
            frame_empty_reg   <= 1'b1;
            overflow_seen_reg <= 1'b0;
            rd_idx_reg        <= 4'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            bit_count_reg     <= bit_count_next;
            select_high_reg   <= select_high_next;
            frame_empty_reg   <= frame_empty_next;
            overflow_seen_reg <= overflow_seen_next;
            rd_idx_reg        <= rd_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        data_byte_reg    <= data_byte_next;
        byte_index_reg   <= byte_index_next;
        last_byte_reg    <= last_byte_next;
        overflow_out_reg <= overflow_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign last_byte  = last_byte_reg;
    assign overflow   = overflow_out_reg;

    // ------------------------------------------------------------------
    // Byte store
    // ------------------------------------------------------------------
    ssfr_store #(
        .DEPTH (CAP)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (store_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_bit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        8'(bit_count_reg) <= 8'(ssfr_pkg::BITS_PER_BYTE * CAP))
        else $error("bit count beyond store capacity");

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ssfr_pkg::ST_LOAD))
        else $error("output byte appeared outside a store readout");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode == ssfr_pkg::MODE_SELECT && ss_level && !frame_empty_reg)
        |=> (state_reg == ssfr_pkg::ST_READ && rd_idx_reg == 4'd0))
        else $error("frame readout did not start at byte zero");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssfr_pkg::ST_LOAD && out_free && rd_last)
        |=> (bit_count_reg == '0 && frame_empty_reg && !overflow_seen_reg
             && last_byte && out_valid))
        else $error("frame state not cleared after last byte");

endmodule

@@ test/ssfr_frame_checker.sv @@
// ----------------------------------------------------------------------------
// SPI frame receiver checker
// Watches the pin event, frame byte and frame length channels, predicts the
// frame bytes of every completed frame and compares them in order.
// ----------------------------------------------------------------------------
module ssfr_frame_checker (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       mode,
    input  logic       mosi_bit,
    input  logic       ss_level,

    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] data_byte,
    input  logic [3:0] byte_index,
    input  logic       last_byte,
    input  logic       overflow,

    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [4:0] cfg_data,

    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] index;
        logic       last;
        logic       ovf;
    } frame_byte_t;

    logic [7:0]  rx_bytes [ssfr_pkg::RESULT_LIMIT];
    logic [7:0]  bit_cnt;
    logic        sel_high;
    logic        frame_empty;
    logic        ovf_seen;
    logic [4:0]  frame_len;
    frame_byte_t frame_bytes_due [$];

    // Zero acts as one byte, anything above the store size as the full store.
    function automatic int active_len(input logic [4:0] len);
        if (len == 5'd0)
            return 1;
        if (len > ssfr_pkg::RESULT_LIMIT)
            return ssfr_pkg::RESULT_LIMIT;
        return int'(len);
    endfunction

    task automatic clear_frame();
        for (int i = 0; i < ssfr_pkg::RESULT_LIMIT; i++)
            rx_bytes[i] = 8'h00;
        bit_cnt     = 8'd0;
        frame_empty = 1'b1;
        ovf_seen    = 1'b0;
    endtask

    task automatic take_pin_event(input logic m, input logic b, input logic s);
        int          len;
        int          k;
        int          byte_pos;
        int          bit_pos;
        frame_byte_t fb;
        len = active_len(frame_len);
        if (m == ssfr_pkg::MODE_CLOCK)
        begin
            if (!sel_high)
            begin
                frame_empty = 1'b0;
                if (bit_cnt < len * ssfr_pkg::BITS_PER_BYTE)
                begin
                    byte_pos = bit_cnt / ssfr_pkg::BITS_PER_BYTE;
                    bit_pos  = ssfr_pkg::BITS_PER_BYTE - 1 - bit_cnt % ssfr_pkg::BITS_PER_BYTE;
                    if (b)
                        rx_bytes[byte_pos][bit_pos] = 1'b1;
                    bit_cnt = bit_cnt + 8'd1;
                end
                else
                begin
                    ovf_seen = 1'b1;
                end
            end
        end
        else
        begin
            sel_high = s;
            if (s && !frame_empty)
            begin
                for (k = 0; k < len; k++)
                begin
                    fb.data  = rx_bytes[k];
                    fb.index = 4'(k);
                    fb.last  = (k == len - 1);
                    fb.ovf   = ovf_seen;
                    frame_bytes_due.push_back(fb);
                end
                clear_frame();
            end
        end
    endtask

    task automatic compare_field(input string fname, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    task automatic check_frame_byte();
        frame_byte_t want;
        if (frame_bytes_due.size() == 0)
        begin
            $display("%0t: frame byte with none expected, actual data %h index %0d",
                     $time, data_byte, byte_index);
            fail_count++;
        end
        else
        begin
            want = frame_bytes_due.pop_front();
            compare_field("data_byte", want.data, data_byte);
            compare_field("byte_index", 8'(want.index), 8'(byte_index));
            compare_field("last_byte", 8'(want.last), 8'(last_byte));
            compare_field("overflow", 8'(want.ovf), 8'(overflow));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            sel_high   = 1'b1;
            frame_len  = ssfr_pkg::FRAME_BYTES_RESET;
            fail_count = 0;
            frame_bytes_due.delete();
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_frame_byte();
            if (cfg_valid && cfg_ready)
                frame_len = cfg_data;
            if (in_valid && !in_stall)
                take_pin_event(mode, mosi_bit, ss_level);
            pending = frame_bytes_due.size();
        end
    end

endmodule

@@ test/tb_spi_slave_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// SPI frame receiver testbench
// Drives pin event transactions into the frame receiver: a directed opening,
// a back-pressure burst, then random frames under several idle and stall
// mixes and frame lengths. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_spi_slave_frame_receiver;

    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;       // settle time after a drain, with margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 25;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       mode      = 1'b0;
    logic       mosi_bit  = 1'b0;
    logic       ss_level  = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic       last_byte;
    logic       overflow;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data  = 5'd0;

    int fail_count;
    int pending;
    int idle_pct   = 0;     // sender gap chance, owned by the stimulus process
    int stall_pct  = 0;     // receiver stall chance
    int hold_req   = 0;     // bumped by the stimulus to request a long hold-off
    int hold_ack   = 0;
    int hold_left  = 0;
    int cycles     = 0;
    int items_sent = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    spi_slave_frame_receiver i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .mosi_bit   (mosi_bit),
        .ss_level   (ss_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .last_byte  (last_byte),
        .overflow   (overflow),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    ssfr_frame_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .mosi_bit   (mosi_bit),
        .ss_level   (ss_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .last_byte  (last_byte),
        .overflow   (overflow),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver side: stall at random, or hold off for a long stretch when the
    // stimulus asks. The hold-off is counted here, apart from the sender, so
    // the sender keeps offering transactions while the block fills up.
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_ack != hold_req)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL spi_slave_frame_receiver");
            $finish;
        end
    end

    // Offer one pin event and hold it until the transaction completes. Called
    // and returns at a falling edge; random gaps drop valid in between.
    task automatic send_event(input logic m, input logic b, input logic s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        mosi_bit <= b;
        ss_level <= s;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // Write the frame length; only called with the block idle.
    task automatic write_frame_len(input logic [4:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pause the sender until every expected frame byte has arrived, then let
    // the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One random frame: mostly well-formed (select low, bits, select high),
    // sometimes overfilled, split by a repeated select low, or left open;
    // the rest is noise and empty select toggles.
    task automatic random_frame(input int cap_bits);
        int shape;
        int nbits;
        int split;
        int i;
        shape = $urandom_range(99);
        if (shape < 12)
        begin
            repeat ($urandom_range(1, 3))
                send_event(ssfr_pkg::MODE_CLOCK, 1'($urandom_range(1)),
                           1'($urandom_range(1)));
        end
        else if (shape < 22)
        begin
            send_event(ssfr_pkg::MODE_SELECT, 1'($urandom_range(1)), 1'b0);
            send_event(ssfr_pkg::MODE_SELECT, 1'($urandom_range(1)), 1'b1);
        end
        else
        begin
            case ($urandom_range(9))
                0:       nbits = cap_bits + $urandom_range(1, 4);
                1:       nbits = cap_bits;
                default: nbits = $urandom_range(1, (cap_bits < 24) ? cap_bits : 24);
            endcase
            split = (shape < 32) ? $urandom_range(1, nbits) : 0;
            send_event(ssfr_pkg::MODE_SELECT, 1'($urandom_range(1)), 1'b0);
            for (i = 0; i < nbits; i++)
            begin
                if (split != 0 && i == split)
                    send_event(ssfr_pkg::MODE_SELECT, 1'($urandom_range(1)), 1'b0);
                send_event(ssfr_pkg::MODE_CLOCK, 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end
            if (shape < 97)
                send_event(ssfr_pkg::MODE_SELECT, 1'($urandom_range(1)), 1'b1);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [4:0] len);
        int start;
        int cap_bytes;
        drain();
        write_frame_len(len);
        idle_pct  = idle;
        stall_pct <= stall;
        cap_bytes = (len == 5'd0) ? 1 :
                    ((len > ssfr_pkg::RESULT_LIMIT) ? ssfr_pkg::RESULT_LIMIT : int'(len));
        start     = items_sent;
        while (items_sent - start < PHASE_ITEMS)
            random_frame(cap_bytes * ssfr_pkg::BITS_PER_BYTE);
    endtask

    initial
    begin
        logic [8:0] pattern;
        int         i;
        pattern = 9'b1011_0010_1;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: clock while deselected is dropped, select high with
        // nothing received gives no frame, select low twice is harmless.
        send_event(ssfr_pkg::MODE_CLOCK, 1'b1, 1'b1);
        send_event(ssfr_pkg::MODE_SELECT, 1'b1, 1'b1);
        send_event(ssfr_pkg::MODE_SELECT, 1'b1, 1'b0);
        send_event(ssfr_pkg::MODE_SELECT, 1'b0, 1'b0);
        for (i = 0; i < 9; i++)
            send_event(ssfr_pkg::MODE_CLOCK, pattern[8 - i], 1'(i));
        // Reset length of 16: a full frame, mostly zero bytes.
        send_event(ssfr_pkg::MODE_SELECT, 1'b0, 1'b1);

        // One-byte frame overfilled: all ones plus dropped bits.
        drain();
        write_frame_len(5'd1);
        send_event(ssfr_pkg::MODE_SELECT, 1'b0, 1'b0);
        repeat (10) send_event(ssfr_pkg::MODE_CLOCK, 1'b1, 1'b0);
        send_event(ssfr_pkg::MODE_SELECT, 1'b1, 1'b1);

        // Lower the length mid-frame; zero acts as one byte.
        drain();
        write_frame_len(5'd16);
        send_event(ssfr_pkg::MODE_SELECT, 1'b1, 1'b0);
        repeat (12) send_event(ssfr_pkg::MODE_CLOCK, 1'b1, 1'b1);
        drain();
        write_frame_len(5'd0);
        send_event(ssfr_pkg::MODE_CLOCK, 1'b0, 1'b0);
        send_event(ssfr_pkg::MODE_SELECT, 1'b0, 1'b1);

        // Length beyond the store acts as the full store: all-zero frame.
        drain();
        write_frame_len(5'd31);
        send_event(ssfr_pkg::MODE_SELECT, 1'b0, 1'b0);
        repeat (8) send_event(ssfr_pkg::MODE_CLOCK, 1'b0, 1'b1);
        send_event(ssfr_pkg::MODE_SELECT, 1'b1, 1'b1);

        // Back pressure: hold the receiver off while short frames keep
        // coming, so readout backs up and the input stalls.
        drain();
        hold_req <= hold_req + 1;
        repeat (4)
        begin
            send_event(ssfr_pkg::MODE_SELECT, 1'($urandom_range(1)), 1'b0);
            repeat ($urandom_range(1, 12))
                send_event(ssfr_pkg::MODE_CLOCK, 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            send_event(ssfr_pkg::MODE_SELECT, 1'($urandom_range(1)), 1'b1);
        end

        // Random frames under each idle mix and several lengths.
        run_phase(0, 0, 5'd1);
        run_phase(61, 0, 5'($urandom_range(2, 8)));
        run_phase(0, 61, 5'd31);
        run_phase(28, 28, 5'($urandom_range(0, 31)));

        drain();
        if (fail_count == 0)
            $display("PASS spi_slave_frame_receiver");
        else
            $display("FAIL spi_slave_frame_receiver");
        $finish;
    end

endmodule
